@@ sv/cht_pkg.sv @@
// Package: shared constants, codes and controller/datapath command types.
`default_nettype none
package cht_pkg;
  localparam int MaxBuckets  = 1024;
  localparam int PoolEntries = 1024;
  localparam int BktW = $clog2(MaxBuckets);
  localparam int EntW = $clog2(PoolEntries);
  localparam int CntW = 11;
  localparam int KeyW = 62;

  localparam logic [2:0] StInsEmpty = 3'd0;
  localparam logic [2:0] StInsColl  = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StMissing  = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  typedef struct packed {
    logic head_clr;  // clear one bucket head after reset
    logic load;      // capture request, start modulo
    logic mod_step;  // one restoring-division step
    logic head_rd;   // read bucket head
    logic ent_rd;    // read entry at cursor
    logic follow;    // cursor <= link of current entry
    logic alloc;     // write new entry, bump pool
    logic link_wr;   // link cursor entry to new entry
    logic head_wr;   // set bucket head to new entry
    logic count;     // probe count += 1
    logic finish;    // build result
    logic [2:0] status;
  } cht_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic is_search;
    logic pool_full;
    logic head_valid;
    logic link_valid;
    logic key_match;
    logic limit;
  } cht_sts_t;
endpackage
`default_nettype wire

@@ sv/cht_if.sv @@
// Interfaces: request and result channels.
`default_nettype none
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [13:0] course_year;
  logic [15:0] course_number;
  logic [31:0] prof_key;
  logic [15:0] record_tag;
  modport source (output valid, operation, course_year, course_number, prof_key,
                  record_tag, input ready);
  modport sink (input valid, operation, course_year, course_number, prof_key,
                record_tag, output ready);
endinterface

interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  entry_index;
  logic [10:0] probe_count;
  logic [15:0] found_tag;
  logic [10:0] collision_total;
  logic [31:0] walk_total;
  modport source (output valid, status, entry_index, probe_count, found_tag,
                  collision_total, walk_total, input ready);
  modport sink (input valid, status, entry_index, probe_count, found_tag,
                collision_total, walk_total, output ready);
endinterface
`default_nettype wire

@@ sv/cht_datapath.sv @@
// Datapath: modulo unit, table memories, cursor, counters and result register.
`default_nettype none
module cht_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [10:0]     cfg_wdata_i,
  input  wire cht_pkg::cht_cmd_t cmd_i,
  output cht_pkg::cht_sts_t    sts_o,
  cht_req_if.sink              req,
  output logic [2:0]           status_o,
  output logic [9:0]           entry_index_o,
  output logic [10:0]          probe_count_o,
  output logic [15:0]          found_tag_o,
  output logic [10:0]          collision_total_o,
  output logic [31:0]          walk_total_o
);
  import cht_pkg::*;

  logic [10:0] tsize_q;
  logic        op_q;
  logic [KeyW-1:0] key_q;
  logic [15:0] tag_q;
  // Restoring division: remainder shifts in one dividend bit a step.
  logic [16:0] rem_q;
  logic [15:0] dvd_q;
  logic [4:0]  mcnt_q;
  logic [BktW-1:0] bkt_q, clr_q;
  logic [EntW-1:0] cur_q, new_q;
  logic            hv_q;
  logic [CntW-1:0] pool_q, probes_q, coll_q;
  logic [31:0] walk_q;

  // Head and link words carry a valid bit above the entry index.
  logic [EntW:0]   head_mem [MaxBuckets];
  logic [KeyW-1:0] key_mem  [PoolEntries];
  logic [15:0]     tag_mem  [PoolEntries];
  logic [EntW:0]   link_mem [PoolEntries];

  logic [EntW:0]   link_rd_q;
  logic [KeyW-1:0] key_rd_q;
  logic [15:0]     tag_rd_q;

  logic [10:0] size_use;
  logic [16:0] rem_sh;
  assign size_use = (tsize_q == '0 || tsize_q > 11'(MaxBuckets)) ? 11'(MaxBuckets) : tsize_q;
  assign rem_sh   = {rem_q[15:0], dvd_q[15]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q  <= 11'(MaxBuckets);
      pool_q   <= '0;
      coll_q   <= '0;
      walk_q   <= '0;
      mcnt_q   <= '0;
      clr_q    <= '0;
    end else begin
      if (cfg_we_i) tsize_q <= cfg_wdata_i;
      if (cmd_i.head_clr) clr_q <= clr_q + BktW'(1);
      if (cmd_i.load) mcnt_q <= '0;
      else if (cmd_i.mod_step) mcnt_q <= mcnt_q + 5'd1;
      if (cmd_i.alloc) pool_q <= pool_q + CntW'(1);
      if (cmd_i.link_wr) begin
        if (coll_q != '1) coll_q <= coll_q + CntW'(1);
        if ({1'b0, walk_q} + 33'(probes_q) > 33'hFFFF_FFFF) walk_q <= '1;
        else walk_q <= walk_q + 32'(probes_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req.operation;
      key_q <= {req.course_year, req.course_number, req.prof_key};
      tag_q <= req.record_tag;
      dvd_q <= req.course_number;
      rem_q <= '0;
      probes_q <= '0;
      new_q <= pool_q[EntW-1:0];
    end
    if (cmd_i.mod_step) begin
      dvd_q <= {dvd_q[14:0], 1'b0};
      if (rem_sh >= 17'(size_use)) rem_q <= rem_sh - 17'(size_use);
      else rem_q <= rem_sh;
    end
    if (mcnt_q == 5'd16) bkt_q <= rem_q[BktW-1:0];
    if (cmd_i.head_rd) {hv_q, cur_q} <= head_mem[bkt_q];
    if (cmd_i.ent_rd) begin
      key_rd_q  <= key_mem[cur_q];
      tag_rd_q  <= tag_mem[cur_q];
      link_rd_q <= link_mem[cur_q];
    end
    if (cmd_i.follow) cur_q <= link_rd_q[EntW-1:0];
    if (cmd_i.count && probes_q != '1) probes_q <= probes_q + CntW'(1);
    if (cmd_i.alloc) begin
      key_mem[new_q] <= key_q;
      tag_mem[new_q] <= tag_q;
    end
    // A new entry starts as a chain end; a link write makes it the successor.
    if (cmd_i.alloc || cmd_i.link_wr)
      link_mem[cmd_i.alloc ? new_q : cur_q] <= cmd_i.alloc ? '0 : {1'b1, new_q};
    if (cmd_i.head_clr || cmd_i.head_wr)
      head_mem[cmd_i.head_clr ? clr_q : bkt_q] <= cmd_i.head_clr ? '0 : {1'b1, new_q};
    if (cmd_i.finish) begin
      status_o <= cmd_i.status;
      entry_index_o <= '0;
      probe_count_o <= '0;
      found_tag_o <= '0;
      case (cmd_i.status)
        StInsEmpty: entry_index_o <= new_q;
        StInsColl: begin
          entry_index_o <= new_q;
          probe_count_o <= probes_q;
        end
        StFound: begin
          entry_index_o <= cur_q;
          probe_count_o <= probes_q;
          found_tag_o <= tag_rd_q;
        end
        StMissing: probe_count_o <= probes_q;
        default: ;
      endcase
    end
  end
  // Totals shown on the result are the ones after this step's update.
  assign collision_total_o = coll_q;
  assign walk_total_o      = walk_q;

  assign sts_o.clr_done   = (clr_q == BktW'(MaxBuckets - 1));
  assign sts_o.mod_done   = (mcnt_q == 5'd16);
  assign sts_o.is_search  = op_q;
  assign sts_o.pool_full  = (pool_q >= 11'(PoolEntries));
  assign sts_o.head_valid = hv_q;
  assign sts_o.link_valid = link_rd_q[EntW];
  assign sts_o.key_match  = (key_rd_q == key_q);
  assign sts_o.limit      = (probes_q >= 11'(PoolEntries));
endmodule
`default_nettype wire

@@ sv/cht_ctrl.sv @@
// Controller: sequences modulo, chain walk, update and result handshake.
`default_nettype none
module cht_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  input  wire cht_pkg::cht_sts_t sts_i,
  output cht_pkg::cht_cmd_t     cmd_o
);
  import cht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_HWAIT, S_ERD, S_EWAIT, S_EVAL, S_DONE, S_OUT
  } state_e;
  state_e state_q;
  logic [2:0] st_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.status = st_q;
    case (state_q)
      S_CLEAR: cmd_o.head_clr = 1'b1;
      S_IDLE: cmd_o.load = req_valid_i;
      S_MOD: cmd_o.mod_step = !sts_i.mod_done;
      S_HEAD: cmd_o.head_rd = 1'b1;
      S_HWAIT: begin
        if (!sts_i.is_search && !sts_i.pool_full) begin
          cmd_o.alloc = 1'b1;
          cmd_o.head_wr = !sts_i.head_valid;
        end
      end
      // Every visited node is counted on its entry read.
      S_ERD: begin
        cmd_o.ent_rd = 1'b1;
        cmd_o.count = 1'b1;
      end
      S_EVAL: begin
        if (!sts_i.is_search) begin
          if (sts_i.link_valid && !sts_i.limit) cmd_o.follow = 1'b1;
          else cmd_o.link_wr = 1'b1;
        end else begin
          if (!sts_i.key_match && sts_i.link_valid && !sts_i.limit)
            cmd_o.follow = 1'b1;
        end
      end
      S_DONE: cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q <= StMissing;
    end else begin
      case (state_q)
        S_CLEAR: if (sts_i.clr_done) state_q <= S_IDLE;
        S_IDLE: if (req_valid_i) state_q <= S_MOD;
        S_MOD: if (sts_i.mod_done) state_q <= S_HEAD;
        S_HEAD: state_q <= S_HWAIT;
        S_HWAIT: begin
          if (!sts_i.is_search && sts_i.pool_full) begin
            st_q <= StFull; state_q <= S_DONE;
          end else if (!sts_i.head_valid) begin
            st_q <= sts_i.is_search ? StMissing : StInsEmpty;
            state_q <= S_DONE;
          end else state_q <= S_ERD;
        end
        S_ERD: state_q <= S_EWAIT;
        S_EWAIT: state_q <= S_EVAL;
        S_EVAL: begin
          if (!sts_i.is_search) begin
            if (sts_i.link_valid && !sts_i.limit) state_q <= S_ERD;
            else begin st_q <= StInsColl; state_q <= S_DONE; end
          end else if (sts_i.key_match) begin
            st_q <= StFound; state_q <= S_DONE;
          end else if (sts_i.link_valid && !sts_i.limit) state_q <= S_ERD;
          else begin st_q <= StMissing; state_q <= S_DONE; end
        end
        S_DONE: state_q <= S_OUT;
        S_OUT: if (rsp_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/chained_hash_table_core.sv @@
// Top level: separate-chaining hash table core.
//
//  channel | dir | handshake      | content
//  req     | in  | valid/ready    | operation, key fields, record tag
//  rsp     | out | valid/ready    | status, index, probes, tag, totals
//  cfg     | in  | write enable   | table_size (11 bits)
//
// Each request passes in turn through the bit-serial modulo unit, the bucket head
// read and one registered entry read per chain node visited; then the result is
// built and presented, and the core returns to idle.
// After reset a clearing pass empties all 1024 bucket heads; no request
// is taken during it.
// A result waits in its register until taken; no request is taken meanwhile.
`default_nettype none
module chained_hash_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  cht_req_if.sink          req,
  cht_rsp_if.source        rsp
);
  import cht_pkg::*;

  cht_cmd_t cmd;
  cht_sts_t sts;

  // The controller steers the datapath only through the command and status words.
  cht_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_o(req.ready),
    .rsp_valid_o(rsp.valid), .rsp_ready_i(rsp.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  cht_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .cmd_i(cmd), .sts_o(sts), .req(req),
    .status_o(rsp.status), .entry_index_o(rsp.entry_index),
    .probe_count_o(rsp.probe_count), .found_tag_o(rsp.found_tag),
    .collision_total_o(rsp.collision_total), .walk_total_o(rsp.walk_total)
  );
endmodule
`default_nettype wire

@@ sv/cht_checker.sv @@
// Checker: port-level properties of the hash table core, with its bind.
`default_nettype none
module cht_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid, req_ready, rsp_valid, rsp_ready,
  input wire logic [2:0] status,
  input wire logic [10:0] collision_total
);
  import cht_pkg::*;

  a_no_req_while_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken with result pending");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> status <= StFull) else $error("bad status");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("result dropped");
  a_coll_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |=> collision_total >= $past(collision_total))
    else $error("collision total went down");
endmodule

bind chained_hash_table_core cht_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .collision_total(rsp.collision_total)
);
`default_nettype wire

@@ tb/sv/chained_hash_table_core_tb.sv @@
// Testbench for chained_hash_table_core: directed and random requests against a hash table model.
`timescale 1ns / 1ps
module chained_hash_table_core_tb;
  import cht_pkg::*;

  localparam int LimitCycles = 10000000;

  typedef struct {
    bit        op;
    bit [13:0] year;
    bit [15:0] number;
    bit [31:0] prof;
    bit [15:0] tag;
  } request_t;

  typedef struct {
    bit [2:0]  status;
    bit [9:0]  index;
    bit [10:0] probes;
    bit [15:0] tag;
    bit [10:0] collisions;
    bit [31:0] walked;
  } answer_t;

  typedef struct {
    request_t rq;
    bit       typed;
    answer_t  ans;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  cht_req_if req_ch ();
  cht_rsp_if rsp_ch ();

  chained_hash_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the table, kept by the predictor.
  bit [10:0] table_size_q;
  bit [9:0]  head_idx [MaxBuckets];
  bit        head_ok [MaxBuckets];
  bit [61:0] ent_key [PoolEntries];
  bit [15:0] ent_tag [PoolEntries];
  bit [9:0]  ent_next [PoolEntries];
  bit        next_ok [PoolEntries];
  int unsigned used_entries;
  bit [10:0] coll_count;
  bit [31:0] walk_count;

  answer_t   pending_results[$];
  request_t  inserted_keys[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Apply one request to the shadow table and return the answer it must give.
  function automatic answer_t hash_apply(request_t r);
    answer_t a;
    int unsigned size;
    int unsigned bkt;
    int unsigned cur;
    int unsigned steps;
    bit [61:0] key;
    key = {r.year, r.number, r.prof};
    size = (table_size_q == 0 || table_size_q > MaxBuckets) ? MaxBuckets : 32'(table_size_q);
    bkt = r.number % size;
    a = '{default: 0};
    if (r.op == 1'b0) begin
      if (used_entries >= PoolEntries) begin
        a.status = StFull;
      end else begin
        a.index = used_entries[9:0];
        ent_key[used_entries] = key;
        ent_tag[used_entries] = r.tag;
        next_ok[used_entries] = 1'b0;
        if (!head_ok[bkt]) begin
          head_idx[bkt] = used_entries[9:0];
          head_ok[bkt] = 1'b1;
          a.status = StInsEmpty;
        end else begin
          cur = 32'(head_idx[bkt]);
          steps = 1;
          while (next_ok[cur] && steps < PoolEntries) begin
            cur = 32'(ent_next[cur]);
            steps++;
          end
          ent_next[cur] = used_entries[9:0];
          next_ok[cur] = 1'b1;
          a.probes = (steps > 2047) ? 11'd2047 : steps[10:0];
          if (coll_count != 11'd2047) coll_count++;
          walk_count = (walk_count > 32'hFFFF_FFFF - steps) ? 32'hFFFF_FFFF
                                                             : walk_count + steps;
          a.status = StInsColl;
        end
        used_entries++;
      end
    end else begin
      a.status = StMissing;
      if (head_ok[bkt]) begin
        cur = 32'(head_idx[bkt]);
        steps = 0;
        forever begin
          steps++;
          if (ent_key[cur] == key) begin
            a.status = StFound;
            a.index = cur[9:0];
            a.tag = ent_tag[cur];
            break;
          end
          if (!next_ok[cur] || steps >= PoolEntries) break;
          cur = 32'(ent_next[cur]);
        end
        a.probes = (steps > 2047) ? 11'd2047 : steps[10:0];
      end
    end
    a.collisions = coll_count;
    a.walked = walk_count;
    return a;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("t=%0t %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Result side: random stalls, then compare each accepted result with the oldest one due.
  initial begin
    int unsigned stall;
    bit took;
    answer_t w;
    answer_t got;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      // Outputs only move at the rising edge, so the falling edge sees what the next edge takes.
      took = 1'b0;
      while (!took) begin
        @(negedge clk_i);
        took = rsp_ch.valid;
        got.status     = rsp_ch.status;
        got.index      = rsp_ch.entry_index;
        got.probes     = rsp_ch.probe_count;
        got.tag        = rsp_ch.found_tag;
        got.collisions = rsp_ch.collision_total;
        got.walked     = rsp_ch.walk_total;
        @(posedge clk_i);
      end
      if (pending_results.size() == 0) begin
        $display("t=%0t result with no request outstanding", $time);
        mismatches++;
      end else begin
        w = pending_results.pop_front();
        if (got.status !== w.status) flag_mismatch("status", got.status, w.status);
        if (got.index !== w.index) flag_mismatch("entry_index", got.index, w.index);
        if (got.probes !== w.probes) flag_mismatch("probe_count", got.probes, w.probes);
        if (got.tag !== w.tag) flag_mismatch("found_tag", got.tag, w.tag);
        if (got.collisions !== w.collisions)
          flag_mismatch("collision_total", got.collisions, w.collisions);
        if (got.walked !== w.walked) flag_mismatch("walk_total", got.walked, w.walked);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request after a random gap; the expectation is queued on acceptance.
  task automatic send_request(input request_t r, input bit typed, input answer_t given);
    int unsigned gap;
    bit hit;
    answer_t a;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= r.op;
    req_ch.course_year   <= r.year;
    req_ch.course_number <= r.number;
    req_ch.prof_key      <= r.prof;
    req_ch.record_tag    <= r.tag;
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk_i);
      hit = req_ch.ready;
      @(posedge clk_i);
    end
    a = hash_apply(r);
    pending_results.insert(pending_results.size(), typed ? given : a);
    if (r.op == 1'b0) inserted_keys.insert(inserted_keys.size(), r);
  endtask

  // Wait for the table to drain, then write the size register.
  task automatic write_table_size(input bit [10:0] size);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_size_q = size;
  endtask

  function automatic request_t random_request(int unsigned size);
    request_t r;
    request_t k;
    r.op = ($urandom_range(0, 99) >= 88);
    r.year = 14'($urandom_range(0, 9999));
    r.number = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 4 * size)) : 16'($urandom);
    r.prof = $urandom;
    r.tag = 16'($urandom);
    // Most searches look for a key that is really stored; some tweak it to miss in a live chain.
    if (r.op && inserted_keys.size() != 0 && $urandom_range(0, 9) < 7) begin
      k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      r.year = k.year;
      r.number = k.number;
      r.prof = ($urandom_range(0, 9) == 0) ? k.prof ^ 32'h1 : k.prof;
    end
    return r;
  endfunction

  initial begin
    row_t rows[] = '{
      // Search of an empty table.
      '{'{1'b1, 14'd0, 16'd0, 32'd0, 16'd0}, 1'b1,
        '{StMissing, 10'd0, 11'd0, 16'd0, 11'd0, 32'd0}},
      // First insert lands in an empty bucket.
      '{'{1'b0, 14'd0, 16'd0, 32'd0, 16'd0}, 1'b1,
        '{StInsEmpty, 10'd0, 11'd0, 16'd0, 11'd0, 32'd0}},
      // Same bucket with a different key collides.
      '{'{1'b0, 14'd9999, 16'd1024, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
        '{StInsColl, 10'd1, 11'd1, 16'd0, 11'd1, 32'd1}},
      '{'{1'b0, 14'd9999, 16'hFFFF, 32'hFFFF_FFFF, 16'hA5A5}, 1'b1,
        '{StInsEmpty, 10'd2, 11'd0, 16'd0, 11'd1, 32'd1}},
      '{'{1'b1, 14'd9999, 16'd1024, 32'hFFFF_FFFF, 16'd0}, 1'b1,
        '{StFound, 10'd1, 11'd2, 16'hFFFF, 11'd1, 32'd1}},
      '{'{1'b1, 14'd0, 16'd0, 32'd0, 16'd0}, 1'b1,
        '{StFound, 10'd0, 11'd1, 16'd0, 11'd1, 32'd1}},
      // Miss at the end of a two-node chain.
      '{'{1'b1, 14'd0, 16'd2048, 32'd0, 16'd0}, 1'b1,
        '{StMissing, 10'd0, 11'd2, 16'd0, 11'd1, 32'd1}},
      // Duplicate key is appended; a search still finds the earlier one.
      '{'{1'b0, 14'd9999, 16'd1024, 32'hFFFF_FFFF, 16'h1234}, 1'b1,
        '{StInsColl, 10'd3, 11'd2, 16'd0, 11'd2, 32'd3}},
      '{'{1'b1, 14'd9999, 16'd1024, 32'hFFFF_FFFF, 16'd0}, 1'b1,
        '{StFound, 10'd1, 11'd2, 16'hFFFF, 11'd2, 32'd3}},
      '{'{1'b1, 14'd9999, 16'hFFFF, 32'hFFFF_FFFF, 16'd0}, 1'b0, '{default: 0}},
      '{'{1'b0, 14'd5461, 16'h5555, 32'h5555_5555, 16'h5555}, 1'b0, '{default: 0}},
      '{'{1'b0, 14'd2730, 16'hAAAA, 32'hAAAA_AAAA, 16'hAAAA}, 1'b0, '{default: 0}},
      '{'{1'b1, 14'd5461, 16'h5555, 32'h5555_5555, 16'd0}, 1'b0, '{default: 0}},
      '{'{1'b1, 14'd2730, 16'hAAAA, 32'hAAAA_AAAB, 16'd0}, 1'b0, '{default: 0}}
    };
    bit [10:0] sizes[] = '{11'd1, 11'd7, 11'd1023, 11'd0, 11'd2047, 11'd64, 11'd1024};
    int unsigned per_phase;
    int unsigned eff;
    answer_t none;

    none = '{default: 0};
    table_size_q = 11'd1024;
    used_entries = 0;
    coll_count = '0;
    walk_count = '0;
    foreach (head_ok[i]) head_ok[i] = 1'b0;
    foreach (next_ok[i]) next_ok[i] = 1'b0;
    foreach (ent_key[i]) ent_key[i] = '0;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= 1'b0;
    req_ch.course_year   <= '0;
    req_ch.course_number <= '0;
    req_ch.prof_key      <= '0;
    req_ch.record_tag    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].ans);

    // Random requests under each table size in turn.
    foreach (sizes[p]) begin
      write_table_size(sizes[p]);
      eff = (sizes[p] == 0 || sizes[p] > MaxBuckets) ? MaxBuckets : 32'(sizes[p]);
      per_phase = (sizes[p] == 1) ? 15 : 130;
      for (int n = 0; n < per_phase; n++) send_request(random_request(eff), 1'b0, none);
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
